/* sv/lgs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// shared types and constants of the life grid generation step block
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 256;

    localparam int OP_W     = 2;
    localparam int ROW_IDX_W = 6;
    localparam int COL_IDX_W = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int POP_W      = 15;
    localparam int GEN_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd256;

    localparam int DIM_MIN = 3;

    localparam logic [POP_W-1:0] POP_MAX = 15'h7fff;

    localparam logic [3:0] NB_SURVIVE = 4'd2;
    localparam logic [3:0] NB_BIRTH   = 4'd3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

endpackage
`default_nettype wire

/* sv/lgs_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* sv/lgs_row_rule.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_row_rule
// next generation of one grid row from the old rows above, at and below it
// ----------------------------------------------------------------------------
module lgs_row_rule #(
    parameter int COLS = 256
) (
    input  logic [COLS-1:0]          i_prev,
    input  logic [COLS-1:0]          i_cur,
    input  logic [COLS-1:0]          i_next,
    input  logic                     i_row_interior,
    input  logic [$clog2(COLS+1)-1:0] i_cols_eff,
    output logic [COLS-1:0]          o_row
);
    import lgs_pkg::*;

    always_comb begin
        logic [COLS+1:0] p;
        logic [COLS+1:0] m;
        logic [COLS+1:0] n;
        logic [3:0]      nb;
        logic            alive;
        p = {1'b0, i_prev, 1'b0};
        m = {1'b0, i_cur, 1'b0};
        n = {1'b0, i_next, 1'b0};
        for (int c = 0; c < COLS; c++) begin
            nb = 4'(p[c]) + 4'(p[c+1]) + 4'(p[c+2]) + 4'(m[c]) + 4'(m[c+2])
               + 4'(n[c]) + 4'(n[c+1]) + 4'(n[c+2]);
            if (m[c+1]) begin
                alive = (nb == NB_SURVIVE) || (nb == NB_BIRTH);
            end else begin
                alive = (nb == NB_BIRTH);
            end
            o_row[c] = i_row_interior && (c >= 1) && ((c + 1) < int'(i_cols_eff)) && alive;
        end
    end

endmodule
`default_nettype wire

/* sv/life_grid_generation_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_generation_step
// b3/s23 life grid held one row per ram word, with write, read, clear and
// generation step operations
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  command   start high while busy low   i_op, i_row_index, i_col_index,
//                                        i_cell_value
//  result    o_done strobe, one cycle    o_read_value, o_live_count,
//                                        o_generation_count
//  config    i_cfg_valid && o_cfg_ready  i_cfg_index, i_cfg_data
//
//  write and read: busy in the S_WRITE or S_READ state after the transaction
//  (ram read, then write back for write), result strobe the cycle after that.
//  clear: all MAX_ROWS rows written, one row written per cycle.
//  step: S_PRIME and S_PRIME2, then S_CALC and S_COUNT for each row: the row
//  read-modify-write loop, with the 8-cell population adder in S_COUNT.
//  reset: clearing pass over all MAX_ROWS rows with busy high; config is taken
//  at any time and o_cfg_ready stays high. results cannot be held off.
// ----------------------------------------------------------------------------
module life_grid_generation_step #(
    parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lgs_pkg::OP_W-1:0]       i_op,
    input  logic [lgs_pkg::ROW_IDX_W-1:0]  i_row_index,
    input  logic [lgs_pkg::COL_IDX_W-1:0]  i_col_index,
    input  logic                           i_cell_value,
    output logic                           o_done,
    output logic                           o_read_value,
    output logic [lgs_pkg::POP_W-1:0]      o_live_count,
    output logic [lgs_pkg::GEN_W-1:0]      o_generation_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lgs_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CLW   = $clog2(MAX_COLS);
    localparam int RE_W  = $clog2(MAX_ROWS + 1);
    localparam int CE_W  = $clog2(MAX_COLS + 1);
    localparam int CHUNK = 8;
    localparam int CNT_W = $clog2(CHUNK + 1);
    localparam int NCH   = (MAX_COLS + CHUNK - 1) / CHUNK;
    localparam int PADW  = NCH * CHUNK;
    localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [RW-1:0] LAST_ROW   = RW'(MAX_ROWS - 1);
    localparam logic [CW-1:0] LAST_CHUNK = CW'(NCH - 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_CLEAR,
        S_PRIME,
        S_PRIME2,
        S_CALC,
        S_COUNT
    } t_state;

    t_state                r_state;
    logic [RW-1:0]         r_row;
    logic                  r_last;
    logic [CW-1:0]         r_chunk;
    logic [RW-1:0]         r_row_addr;
    logic [CLW-1:0]        r_col_addr;
    logic                  r_val;
    logic                  r_inside;
    logic [MAX_COLS-1:0]   r_prev;
    logic [MAX_COLS-1:0]   r_cur;
    logic [PADW-1:0]       r_new;
    logic [POP_W-1:0]      r_acc;
    logic [POP_W-1:0]      r_population;
    logic [GEN_W-1:0]      r_generation;
    logic [ROWS_CFG_W-1:0] r_rows;
    logic [COLS_CFG_W-1:0] r_cols;
    logic                  r_done;
    logic                  r_read_value;
    logic [POP_W-1:0]      r_live_count;
    logic [GEN_W-1:0]      r_generation_count;

    logic                  ram_wr_en;
    logic [RW-1:0]         ram_wr_addr;
    logic [MAX_COLS-1:0]   ram_wr_data;
    logic [RW-1:0]         ram_rd_addr;
    logic [MAX_COLS-1:0]   ram_rd_data;
    logic [MAX_COLS-1:0]   new_row;
    logic [MAX_COLS-1:0]   mod_row;
    logic [RE_W-1:0]       rows_eff;
    logic [CE_W-1:0]       cols_eff;
    logic                  row_interior;
    logic [RW-1:0]         next_addr;
    logic [POP_W-1:0]      acc_next;
    logic                  in_inside;

    function automatic logic [CNT_W-1:0] f_pop(input logic [CHUNK-1:0] v);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < CHUNK; i++) begin
            s = s + CNT_W'(v[i]);
        end
        return s;
    endfunction

    always_comb begin
        if (r_rows < ROWS_CFG_W'(DIM_MIN)) begin
            rows_eff = RE_W'(DIM_MIN);
        end else if (int'(r_rows) > MAX_ROWS) begin
            rows_eff = RE_W'(MAX_ROWS);
        end else begin
            rows_eff = RE_W'(r_rows);
        end
        if (r_cols < COLS_CFG_W'(DIM_MIN)) begin
            cols_eff = CE_W'(DIM_MIN);
        end else if (int'(r_cols) > MAX_COLS) begin
            cols_eff = CE_W'(MAX_COLS);
        end else begin
            cols_eff = CE_W'(r_cols);
        end
    end

    assign row_interior = (r_row != '0) && ((int'(r_row) + 1) < int'(rows_eff));
    assign next_addr    = ((int'(r_row) + 1) < MAX_ROWS) ? (r_row + RW'(1)) : '0;
    assign in_inside    = (int'(i_row_index) < MAX_ROWS) && (int'(i_col_index) < MAX_COLS);

    always_comb begin
        logic [POP_W:0] sum;
        sum = {1'b0, r_acc} + (POP_W + 1)'(f_pop(r_new[CHUNK-1:0]));
        acc_next = sum[POP_W] ? POP_MAX : sum[POP_W-1:0];
    end

    always_comb begin
        mod_row = ram_rd_data;
        mod_row[r_col_addr] = r_val;
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_row;
        ram_wr_data = '0;
        ram_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                ram_rd_addr = RW'(i_row_index);
            end
            S_WRITE: begin
                ram_wr_en   = r_inside;
                ram_wr_addr = r_row_addr;
                ram_wr_data = mod_row;
            end
            S_INIT, S_CLEAR: begin
                ram_wr_en = 1'b1;
            end
            S_PRIME2, S_COUNT: begin
                ram_rd_addr = next_addr;
            end
            S_CALC: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = new_row;
            end
            default: begin
                ram_rd_addr = '0;
            end
        endcase
    end

    lgs_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    lgs_row_rule #(
        .COLS (MAX_COLS)
    ) u_rule (
        .i_prev         (r_prev),
        .i_cur          (r_cur),
        .i_next         (ram_rd_data),
        .i_row_interior (row_interior),
        .i_cols_eff     (cols_eff),
        .o_row          (new_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_row        <= '0;
            r_population <= '0;
            r_generation <= '0;
            r_rows       <= ROWS_RESET;
            r_cols       <= COLS_RESET;
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ROWS) begin
                    r_rows <= i_cfg_data[ROWS_CFG_W-1:0];
                end else if (i_cfg_index == CFG_COLS) begin
                    r_cols <= i_cfg_data[COLS_CFG_W-1:0];
                end
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_row == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_row_addr <= RW'(i_row_index);
                        r_col_addr <= CLW'(i_col_index);
                        r_val      <= i_cell_value;
                        r_inside   <= in_inside;
                        unique case (t_op'(i_op))
                            OP_WRITE: begin
                                r_state <= S_WRITE;
                            end
                            OP_READ: begin
                                r_state <= S_READ;
                            end
                            OP_STEP: begin
                                r_state <= S_PRIME;
                                r_acc   <= '0;
                            end
                            OP_CLEAR: begin
                                r_state <= S_CLEAR;
                                r_row   <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    r_state            <= S_IDLE;
                    r_done             <= 1'b1;
                    r_read_value       <= 1'b0;
                    r_live_count       <= r_population;
                    r_generation_count <= r_generation;
                end
                S_READ: begin
                    r_state            <= S_IDLE;
                    r_done             <= 1'b1;
                    r_read_value       <= r_inside ? ram_rd_data[r_col_addr] : 1'b0;
                    r_live_count       <= r_population;
                    r_generation_count <= r_generation;
                end
                S_CLEAR: begin
                    if (r_row == LAST_ROW) begin
                        r_state            <= S_IDLE;
                        r_population       <= '0;
                        r_done             <= 1'b1;
                        r_read_value       <= 1'b0;
                        r_live_count       <= '0;
                        r_generation_count <= r_generation;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end
                S_PRIME: begin
                    r_state <= S_PRIME2;
                    r_row   <= '0;
                end
                S_PRIME2: begin
                    r_state <= S_CALC;
                    r_cur   <= ram_rd_data;
                end
                S_CALC: begin
                    r_state <= S_COUNT;
                    r_prev  <= r_cur;
                    r_cur   <= ram_rd_data;
                    r_new   <= PADW'(new_row);
                    r_chunk <= '0;
                    if (r_row == LAST_ROW) begin
                        r_last <= 1'b1;
                    end else begin
                        r_last <= 1'b0;
                        r_row  <= r_row + RW'(1);
                    end
                end
                S_COUNT: begin
                    r_acc <= acc_next;
                    r_new <= r_new >> CHUNK;
                    if (r_chunk == LAST_CHUNK) begin
                        if (r_last) begin
                            r_state            <= S_IDLE;
                            r_population       <= acc_next;
                            r_generation       <= r_generation + GEN_W'(1);
                            r_done             <= 1'b1;
                            r_read_value       <= 1'b0;
                            r_live_count       <= acc_next;
                            r_generation_count <= r_generation + GEN_W'(1);
                        end else begin
                            r_state <= S_CALC;
                        end
                    end else begin
                        r_chunk <= r_chunk + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_done             = r_done;
    assign o_read_value       = r_read_value;
    assign o_live_count       = r_live_count;
    assign o_generation_count = r_generation_count;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transaction accepted but block not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_gen_inc: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) && !$stable(r_generation)
        |-> r_generation == $past(r_generation) + GEN_W'(1))
        else $error("generation counter moved by other than one");
`endif

endmodule
`default_nettype wire
